@@ rtl/greedy_box_suppression_assert.svh @@
// Assertion helpers used by the RTL; clock and active-low reset passed in
`ifndef GREEDY_BOX_SUPPRESSION_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_ASSERT_SVH

// Same-cycle implication
`define GBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gbs assertion failed");

// Next-cycle implication
`define GBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gbs assertion failed");

`endif

@@ rtl/gbs_pkg.sv @@
`timescale 1ns / 1ps

package gbs_pkg;

    localparam int COORD_W = 16;
    localparam int AREA_W  = 32;
    localparam int THR_W   = 16;
    localparam int TOTAL_W = 7;
    localparam int UNI_W   = AREA_W + 1;
    localparam int PROD_W  = THR_W + UNI_W;

    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic [COORD_W-1:0] bottom;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
    } t_box;

    localparam int ENTRY_W = $bits(t_box) + AREA_W;

    typedef struct packed {
        logic               vld;
        t_box               kbox;
        logic [AREA_W-1:0]  karea;
    } t_iou_req;

    typedef struct packed {
        logic busy;
        logic hit;
    } t_iou_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } t_state;

    function automatic logic [COORD_W-1:0] extent(input logic [COORD_W-1:0] lo,
                                                  input logic [COORD_W-1:0] hi);
        return (hi > lo) ? (hi - lo) : '0;
    endfunction

    function automatic logic [COORD_W-1:0] overlap(input logic [COORD_W-1:0] a0,
                                                   input logic [COORD_W-1:0] a1,
                                                   input logic [COORD_W-1:0] b0,
                                                   input logic [COORD_W-1:0] b1);
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a1 < b1) ? a1 : b1;
        return extent(lo, hi);
    endfunction

endpackage

@@ rtl/gbs_if.sv @@
`timescale 1ns / 1ps

interface gbs_box_if import gbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               start_of_set;
    logic [COORD_W-1:0] left_edge;
    logic [COORD_W-1:0] top_edge;
    logic [COORD_W-1:0] right_edge;
    logic [COORD_W-1:0] bottom_edge;

    modport source (output valid, start_of_set, left_edge, top_edge, right_edge,
                    bottom_edge, input ready);
    modport sink   (input valid, start_of_set, left_edge, top_edge, right_edge,
                    bottom_edge, output ready);
endinterface

interface gbs_res_if import gbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               keep;
    logic [TOTAL_W-1:0] kept_total;
    logic               overflow;

    modport source (output valid, keep, kept_total, overflow, input ready);
    modport sink   (input valid, keep, kept_total, overflow, output ready);
endinterface

@@ rtl/gbs_ram.sv @@
`timescale 1ns / 1ps

module gbs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/gbs_iou.sv @@
`timescale 1ns / 1ps

module gbs_iou import gbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_iou_req           i_req,
    input  t_box               i_box,
    input  logic [AREA_W-1:0]  i_area,
    input  logic [THR_W-1:0]   i_thr,
    output t_iou_rsp           o_rsp
);

    // stage 1: overlap extents
    logic               r1_vld;
    logic [COORD_W-1:0] r1_ox;
    logic [COORD_W-1:0] r1_oy;
    logic [AREA_W-1:0]  r1_karea;
    // stage 2: intersection area
    logic               r2_vld;
    logic [AREA_W-1:0]  r2_inter;
    logic [AREA_W-1:0]  r2_karea;
    // stage 3: union
    logic               r3_vld;
    logic [AREA_W-1:0]  r3_inter;
    logic [UNI_W-1:0]   r3_uni;
    // stage 4: threshold times union
    logic               r4_vld;
    logic [AREA_W-1:0]  r4_inter;
    logic               r4_nz;
    logic [PROD_W-1:0]  r4_prod;
    // stage 5: compare
    logic               r5_vld;
    logic               r5_hit;

    logic [UNI_W-1:0]   n3_sum;
    logic [UNI_W-1:0]   n3_inter;
    logic [UNI_W-1:0]   n3_uni;
    logic [PROD_W-1:0]  n5_lhs;

    always_comb begin
        n3_sum   = {1'b0, i_area} + {1'b0, r2_karea};
        n3_inter = {1'b0, r2_inter};
        n3_uni   = (n3_sum > n3_inter) ? (n3_sum - n3_inter) : '0;
        // inter scaled by 2^16, widened to the product width
        n5_lhs   = {1'b0, r4_inter, {THR_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r1_vld <= i_req.vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ox    <= overlap(i_box.left, i_box.right, i_req.kbox.left, i_req.kbox.right);
        r1_oy    <= overlap(i_box.top, i_box.bottom, i_req.kbox.top, i_req.kbox.bottom);
        r1_karea <= i_req.karea;

        r2_inter <= AREA_W'(r1_ox) * AREA_W'(r1_oy);
        r2_karea <= r1_karea;

        r3_inter <= r2_inter;
        r3_uni   <= n3_uni;

        r4_inter <= r3_inter;
        r4_nz    <= (r3_uni != '0);
        r4_prod  <= PROD_W'(i_thr) * PROD_W'(r3_uni);

        r5_hit   <= r4_vld && r4_nz && (n5_lhs > r4_prod);
    end

    assign o_rsp.busy = r1_vld | r2_vld | r3_vld | r4_vld | r5_vld;
    assign o_rsp.hit  = r5_vld & r5_hit;

endmodule

@@ rtl/greedy_box_suppression.sv @@
`timescale 1ns / 1ps
// Greedy class-agnostic box suppression by intersection over union.
// i_box carries one detection box per word (corners in unsigned Q12.4, boxes
// in descending score order); start_of_set empties the kept store first.
// o_res returns one word per box: keep, the kept count after the box, and
// overflow when a survivor finds the store full (it is reported, not stored).
// i_cfg_we / i_cfg_wdata write the Q0.16 overlap threshold; write it only
// while no box is in flight.
// Each box passes through ST_AREA, ST_SCAN, ST_DRAIN and ST_WRITE: ST_SCAN
// reads the N kept boxes (at most MAX_KEPT) through the single read port
// of the kept-box memory, one entry per cycle, and each entry passes through
// the five-stage overlap pipeline; ST_DRAIN waits for that pipeline to empty.
// The next box is taken only after ST_WRITE, so boxes are handled one at a
// time.
// Reset clears the kept count and loads the threshold with its default; the
// memory contents are not cleared and need no clearing pass.
// A result waits in an output register while o_res.ready is low; the next
// box is still accepted and scanned, and only its write-back waits for the
// output register to empty.

module greedy_box_suppression import gbs_pkg::*; #(
    parameter int MAX_KEPT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gbs_box_if.sink            i_box,
    gbs_res_if.source          o_res,
    input  logic               i_cfg_we,
    input  logic [THR_W-1:0]   i_cfg_wdata
);

    `include "greedy_box_suppression_assert.svh"

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_KEPT);

    t_state             r_state;
    t_state             n_state;
    t_box               r_box;
    logic [AREA_W-1:0]  r_area;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_issue;
    logic               r_supp;
    logic               r_rd_vld;
    logic [THR_W-1:0]   r_thr;
    logic               r_out_vld;
    logic               r_out_keep;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_ovf;

    logic               in_ready;
    logic               rd_en;
    logic               wr_go;
    logic               wr_en;
    logic               accept;
    logic               slot_free;
    logic               keep;
    logic               room;
    logic [CW-1:0]      cnt_after;
    logic [ENTRY_W-1:0] rdata;
    t_iou_req           req;
    t_iou_rsp           rsp;

    assign accept    = i_box.valid & in_ready;
    assign slot_free = !r_out_vld || o_res.ready;
    assign keep      = !r_supp;
    assign room      = (r_count < MAX_CNT);
    assign wr_en     = wr_go & keep & room;
    assign cnt_after = wr_en ? (r_count + CW'(1)) : r_count;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_box.valid) n_state = ST_AREA;
            end
            ST_AREA: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_issue == r_count) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                // wait for the last compare to leave the pipeline
                if (!r_rd_vld && !rsp.busy) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        wr_go    = 1'b0;
        case (r_state)
            ST_IDLE:  in_ready = 1'b1;
            ST_SCAN:  rd_en    = (r_issue < r_count);
            ST_WRITE: wr_go    = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_issue   <= '0;
            r_supp    <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_thr     <= THR_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (accept) begin
                r_issue <= '0;
                r_supp  <= 1'b0;
                if (i_box.start_of_set) begin
                    r_count <= '0;
                end
            end else begin
                if (rd_en) begin
                    r_issue <= r_issue + CW'(1);
                end
                if (rsp.hit) begin
                    r_supp <= 1'b1;
                end
                r_count <= cnt_after;
            end
            if (wr_go) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_box.left   <= i_box.left_edge;
            r_box.top    <= i_box.top_edge;
            r_box.right  <= i_box.right_edge;
            r_box.bottom <= i_box.bottom_edge;
        end
        if (r_state == ST_AREA) begin
            r_area <= AREA_W'(extent(r_box.left, r_box.right)) *
                      AREA_W'(extent(r_box.top, r_box.bottom));
        end
        if (wr_go) begin
            r_out_keep  <= keep;
            r_out_total <= TOTAL_W'(cnt_after);
            r_out_ovf   <= keep & !room;
        end
    end

    gbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEPT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_box, r_area}),
        .i_re    (rd_en),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (rdata)
    );

    assign req.vld   = r_rd_vld;
    assign req.kbox  = t_box'(rdata[ENTRY_W-1:AREA_W]);
    assign req.karea = rdata[AREA_W-1:0];

    gbs_iou u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_box   (r_box),
        .i_area  (r_area),
        .i_thr   (r_thr),
        .o_rsp   (rsp)
    );

    assign i_box.ready      = in_ready;
    assign o_res.valid      = r_out_vld;
    assign o_res.keep       = r_out_keep;
    assign o_res.kept_total = r_out_total;
    assign o_res.overflow   = r_out_ovf;

    `GBS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= MAX_CNT)
    `GBS_ASSERT_NOW(a_write_quiet, i_clk, i_rst_n, wr_en, !r_rd_vld && !rsp.busy)
    `GBS_ASSERT_NOW(a_ovf_full, i_clk, i_rst_n, o_res.valid && o_res.overflow, o_res.keep && o_res.kept_total == TOTAL_W'(MAX_KEPT))
    `GBS_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, accept && i_box.start_of_set, r_count == '0)

endmodule
